>>> sv/string_isomorphism_check_top_defines.svh
// Assertion helpers for the RTL of the string isomorphism checker.
`ifndef STRING_ISOMORPHISM_CHECK_TOP_DEFINES_SVH
`define STRING_ISOMORPHISM_CHECK_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SIC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by an outcome.
`define SIC_ASSERT_NEXT(label, trig, outcome, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (outcome)) \
    else $error(msg);

`endif

>>> sv/sic_pkg.sv
package sic_pkg;

  localparam int BYTE_W            = 8;
  localparam int ALPHABET_SIZE_DEF = 256;

  // Pair held in the lookup stage while its map reads return.
  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              first;
    logic              last;
  } pair_t;

endpackage

>>> sv/string_isomorphism_check_top.sv
// Isomorphic string checker. Byte pairs of two aligned strings stream in on
// the slave side, one transfer per pair, with tuser marking the first pair
// and tlast the last. The block learns a one-to-one byte mapping in a forward
// and a reverse map memory and gives one result transfer after each last pair:
// bit 0 of m_axis_tdata is 1 when no pair broke the mapping. A pair is taken
// every cycle unless the slave side pauses; its result is registered after the lookup stage.
// The rate is set by the read-modify-write loop on the two map memories,
// closed with a one-entry forward path from the write stage to the read data.
// The slave side pauses only while a finished result waits on the master side
// and the pair in the lookup stage is a last pair as well. No clearing pass is
// needed after reset: per-entry valid bits in flip-flops clear at once.
`include "string_isomorphism_check_top_defines.svh"

module string_isomorphism_check_top
  import sic_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*BYTE_W-1:0] s_axis_tdata,   // char_a [7:0], char_b [15:8]
  input  logic                s_axis_tuser,   // first_pair
  input  logic                s_axis_tlast,   // last_pair
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [BYTE_W-1:0]   m_axis_tdata    // equivalent [0], zeros above
);

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam logic [BYTE_W:0] ALPHA_LIM = (BYTE_W + 1)'(ALPHABET_SIZE);

  // Map memories with registered read data.
  logic [AW-1:0] fmap [ALPHABET_SIZE];
  logic [AW-1:0] rmap [ALPHABET_SIZE];
  logic [AW-1:0] f_rdata;
  logic [AW-1:0] r_rdata;

  logic [ALPHABET_SIZE-1:0] fvalid;
  logic [ALPHABET_SIZE-1:0] rvalid;
  logic [ALPHABET_SIZE-1:0] fvalid_next;
  logic [ALPHABET_SIZE-1:0] rvalid_next;
  logic                     mismatch;
  logic                     mismatch_next;

  pair_t         s1;
  logic          s1_valid;
  logic          fwd_f_hit;
  logic          fwd_r_hit;
  logic [AW-1:0] fwd_f_val;
  logic [AW-1:0] fwd_r_val;

  logic          out_valid;
  logic          out_eq;

  logic [BYTE_W-1:0] in_a;
  logic [BYTE_W-1:0] in_b;
  logic              accept;
  logic              stall;
  logic              advance;
  logic              in_range;
  logic [AW-1:0]     ia;
  logic [AW-1:0]     ib;
  logic              fv;
  logic              rv;
  logic [AW-1:0]     fmap_val;
  logic [AW-1:0]     rmap_val;
  logic              s1_write;

  assign in_a   = s_axis_tdata[BYTE_W-1:0];
  assign in_b   = s_axis_tdata[2*BYTE_W-1:BYTE_W];

  // Hold the lookup stage while its result cannot be handed on.
  assign stall         = s1_valid && s1.last && out_valid && !m_axis_tready;
  assign s_axis_tready = !stall;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign advance       = s1_valid && !stall;

  assign ia       = s1.a[AW-1:0];
  assign ib       = s1.b[AW-1:0];
  assign in_range = ({1'b0, s1.a} < ALPHA_LIM) && ({1'b0, s1.b} < ALPHA_LIM);

  // A first pair sees both maps empty.
  assign fv = in_range && !s1.first && fvalid[ia];
  assign rv = in_range && !s1.first && rvalid[ib];

  assign fmap_val = fwd_f_hit ? fwd_f_val : f_rdata;
  assign rmap_val = fwd_r_hit ? fwd_r_val : r_rdata;

  assign s1_write = advance && in_range && !fv && !rv;

  always_comb begin
    mismatch_next = (mismatch && !s1.first) || !in_range
                    || (fv && (fmap_val != ib)) || (rv && (rmap_val != ia));
    fvalid_next = s1.first ? '0 : fvalid;
    rvalid_next = s1.first ? '0 : rvalid;
    if (s1_write) begin
      fvalid_next[ia] = 1'b1;
      rvalid_next[ib] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      fmap[ia] <= ib;
      rmap[ib] <= ia;
    end
    if (accept) begin
      f_rdata <= fmap[in_a[AW-1:0]];
      r_rdata <= rmap[in_b[AW-1:0]];
    end
  end

  // Forward the entry written this cycle to the pair that reads it.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.a      <= in_a;
      s1.b      <= in_b;
      s1.first  <= s_axis_tuser;
      s1.last   <= s_axis_tlast;
      fwd_f_hit <= s1_write && (s1.a == in_a);
      fwd_r_hit <= s1_write && (s1.b == in_b);
      fwd_f_val <= ib;
      fwd_r_val <= ia;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fvalid    <= '0;
      rvalid    <= '0;
      mismatch  <= 1'b0;
      out_valid <= 1'b0;
      out_eq    <= 1'b0;
    end else begin
      s1_valid <= stall || accept;
      if (advance) begin
        fvalid   <= fvalid_next;
        rvalid   <= rvalid_next;
        mismatch <= mismatch_next;
      end
      if (advance && s1.last) begin
        out_valid <= 1'b1;
        out_eq    <= !mismatch_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(BYTE_W - 1){1'b0}}, out_eq};

  `SIC_ASSERT(a_valid_balance, $countones(fvalid) == $countones(rvalid), "map valid counts differ")
  `SIC_ASSERT_NEXT(a_write_marks, s1_write, fvalid[$past(ia)] && rvalid[$past(ib)], "write unmarked")
  `SIC_ASSERT_NEXT(a_first_clean, s1_write && s1.first, !mismatch, "first pair left mismatch set")
  `SIC_ASSERT_NEXT(a_stall_holds, stall, s1_valid && out_valid, "stalled stage lost its pair")

endmodule

>>> test/sic_equivalence_checker.sv
module sic_equivalence_checker
  import sic_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [2*BYTE_W-1:0] s_axis_tdata,   // char_a [7:0], char_b [15:8]
  input  logic                s_axis_tuser,   // first_pair
  input  logic                s_axis_tlast,   // last_pair
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [BYTE_W-1:0]   m_axis_tdata,   // equivalent [0], zeros above
  output int                  fail_count,
  output int                  verdicts_pending
);

  localparam int CODES = 2**BYTE_W;

  logic [BYTE_W-1:0] a_to_b [CODES];
  logic [BYTE_W-1:0] b_to_a [CODES];
  bit                a_bound [CODES];
  bit                b_bound [CODES];
  bit                broken;
  bit                verdict_q [$];

  task automatic forget_mapping();
    for (int i = 0; i < CODES; i++) begin
      a_bound[i] = 1'b0;
      b_bound[i] = 1'b0;
    end
    broken = 1'b0;
  endtask

  // In range, bind a->b and b->a when both are free, else check the binding.
  task automatic learn_pair(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
    if (a >= ALPHABET_SIZE || b >= ALPHABET_SIZE) begin
      broken = 1'b1;
    end else if (!a_bound[a] && !b_bound[b]) begin
      a_to_b[a]  = b;
      b_to_a[b]  = a;
      a_bound[a] = 1'b1;
      b_bound[b] = 1'b1;
    end else begin
      if (a_bound[a] && a_to_b[a] != b) broken = 1'b1;
      if (b_bound[b] && b_to_a[b] != a) broken = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      forget_mapping();
      verdict_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) forget_mapping();
        learn_pair(s_axis_tdata[BYTE_W-1:0], s_axis_tdata[2*BYTE_W-1:BYTE_W]);
        if (s_axis_tlast) verdict_q.push_back(!broken);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with no verdict waiting: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want) begin
            $error("equivalent: expected %0d, got %0d", want, m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tdata[BYTE_W-1:1] !== '0) begin
            $error("tdata pad: expected 0, got %h", m_axis_tdata[BYTE_W-1:1]);
            fail_count++;
          end
        end
      end
    end
    verdicts_pending = verdict_q.size();
  end

endmodule

>>> test/tb_string_isomorphism_check_top.sv
module tb_string_isomorphism_check_top
  import sic_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 350;
  localparam int MAX_STR_LEN  = 48;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [2*BYTE_W-1:0] s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [BYTE_W-1:0]   m_axis_tdata;

  int fail_count;
  int verdicts_pending;
  int idle_pct;
  int stall_pct;
  int pairs_sent;
  int cycles;

  string_isomorphism_check_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sic_equivalence_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL string_isomorphism_check_top");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pair(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                           input bit first, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pairs_sent++;
    @(negedge clk);
  endtask

  // Stream one string pair: B is either a relabelling of A through a random
  // byte permutation (optionally spoiled at one position) or drawn freely.
  task automatic send_string(input int len, input bit mapped, input bit spoil,
                             input bit mark_first, input bit mark_last);
    logic [BYTE_W-1:0] perm [2**BYTE_W];
    logic [BYTE_W-1:0] a_pool [64];
    logic [BYTE_W-1:0] b_pool [64];
    logic [BYTE_W-1:0] a_chars [MAX_STR_LEN];
    logic [BYTE_W-1:0] b_chars [MAX_STR_LEN];
    logic [BYTE_W-1:0] swap;
    int                pool_n;
    int                j;
    pool_n = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 8);
    for (int i = 0; i < 64; i++) begin
      a_pool[i] = BYTE_W'($urandom);
      b_pool[i] = BYTE_W'($urandom);
    end
    for (int i = 0; i < 2**BYTE_W; i++) perm[i] = BYTE_W'(i);
    for (int i = 2**BYTE_W - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      swap    = perm[i];
      perm[i] = perm[j];
      perm[j] = swap;
    end
    for (int i = 0; i < len; i++) begin
      a_chars[i] = a_pool[$urandom_range(pool_n - 1)];
      b_chars[i] = mapped ? perm[a_chars[i]] : b_pool[$urandom_range(pool_n - 1)];
    end
    if (spoil) begin
      j = $urandom_range(len - 1);
      b_chars[j] = b_chars[j] ^ (8'h01 << $urandom_range(BYTE_W - 1));
    end
    for (int i = 0; i < len; i++)
      send_pair(a_chars[i], b_chars[i], mark_first && i == 0, mark_last && i == len - 1);
  endtask

  task automatic stream_random_strings(input int idle, input int stall, input int items);
    int goal;
    int roll;
    int len;
    idle_pct  = idle;
    stall_pct = stall;
    goal      = pairs_sent + items;
    while (pairs_sent < goal) begin
      roll = $urandom_range(99);
      len  = ($urandom_range(99) < 85) ? $urandom_range(1, 12)
                                       : $urandom_range(13, MAX_STR_LEN);
      // mostly well-formed strings; the rest drop the first or last mark
      send_string(len, roll < 75, roll < 75 && $urandom_range(99) < 35,
                  !(roll >= 85 && roll < 95), roll < 95);
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    pairs_sent    = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no first mark straight after reset: tables start empty
    send_pair(8'h00, 8'hFF, 1'b0, 1'b0);
    send_pair(8'hFF, 8'h00, 1'b0, 1'b1);
    // single pair comparison
    send_pair(8'hA5, 8'h5A, 1'b1, 1'b1);
    // continue after a last pair without a first mark: A5 is still bound to 5A
    send_pair(8'hA5, 8'h00, 1'b0, 1'b1);
    // forward conflict
    send_pair(8'h01, 8'h02, 1'b1, 1'b0);
    send_pair(8'h01, 8'h03, 1'b0, 1'b1);
    // reverse conflict
    send_pair(8'h01, 8'h02, 1'b1, 1'b0);
    send_pair(8'h03, 8'h02, 1'b0, 1'b1);
    // consistent repeats
    send_pair(8'h10, 8'h20, 1'b1, 1'b0);
    send_pair(8'h11, 8'h21, 1'b0, 1'b0);
    send_pair(8'h10, 8'h20, 1'b0, 1'b0);
    send_pair(8'h11, 8'h21, 1'b0, 1'b1);
    // identity at the byte extremes
    send_pair(8'hFF, 8'hFF, 1'b1, 1'b0);
    send_pair(8'h00, 8'h00, 1'b0, 1'b1);
    // swapped pair of codes
    send_pair(8'h55, 8'hAA, 1'b1, 1'b0);
    send_pair(8'hAA, 8'h55, 1'b0, 1'b1);

    stream_random_strings(0, 0, PHASE_ITEMS);
    stream_random_strings(47, 0, PHASE_ITEMS);
    stream_random_strings(0, 47, PHASE_ITEMS);
    stream_random_strings(22, 22, PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS string_isomorphism_check_top");
    end else begin
      $display("FAIL string_isomorphism_check_top");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/sic_pkg.sv
sv/string_isomorphism_check_top.sv
test/sic_equivalence_checker.sv
test/tb_string_isomorphism_check_top.sv
